@@ rtl/hex_capture_line_parser_defines.svh @@
// Assertion macros shared by the parser RTL.
`ifndef HEX_CAPTURE_LINE_PARSER_DEFINES_SVH
`define HEX_CAPTURE_LINE_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCLP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hex capture line parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define HCLP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hex capture line parser check failed");

`endif

@@ rtl/hclp_pkg.sv @@
package hclp_pkg;

   localparam int COUNT_WIDTH     = 16;
   localparam int OUT_COUNT_WIDTH = 16;
   localparam int RSP_DATA_WIDTH  = 48;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_C     = 8'h43;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X_UP  = 8'h58;
   localparam logic [7:0] CHAR_X_LOW = 8'h78;

   localparam int EF_DIR   = 0;
   localparam int EF_FORM  = 1;
   localparam int EF_OPHEX = 2;
   localparam int EF_LARGE = 3;
   localparam int EF_PAYHEX = 4;

   typedef enum logic [3:0] {
      PH_LSTART,
      PH_COMMENT,
      PH_PRE_DIR,
      PH_DIR,
      PH_PRE_OP,
      PH_OP,
      PH_PRE_PAY,
      PH_PAY,
      PH_REST
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_SKIPPED,
      ST_BAD_DIR,
      ST_BAD_FORM,
      ST_OP_NONHEX,
      ST_OP_LARGE,
      ST_ODD_PAYLOAD,
      ST_PAY_NONHEX
   } status_type;

   typedef struct packed {
      phase_type              phase;
      logic [7:0]             dir_char;
      logic [1:0]             token_length;
      logic [31:0]            opcode_accumulator;
      logic [4:0]             error_flags;
      logic [3:0]             high_nibble;
      logic                   nibble_half;
      logic [COUNT_WIDTH-1:0] payload_count;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:              PH_LSTART,
      dir_char:           8'h00,
      token_length:       2'd0,
      opcode_accumulator: 32'h0,
      error_flags:        5'h00,
      high_nibble:        4'h0,
      nibble_half:        1'b0,
      payload_count:      '0
   };

   // Returns the digit value in the low four bits and a valid flag on top.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   // Finishes the token or gap the line is in and moves to the next gap.
   function automatic state_type close_token(input state_type s);
      state_type r;
      r = s;
      case (s.phase)
         PH_PRE_DIR, PH_DIR: begin
            if (s.token_length != 2'd1 || (s.dir_char != CHAR_C && s.dir_char != CHAR_S)) begin
               r.error_flags[EF_DIR] = 1'b1;
            end
            r.phase = PH_PRE_OP;
            r.token_length = 2'd0;
         end
         PH_PRE_OP, PH_OP: begin
            if (s.token_length != 2'd3) begin
               r.error_flags[EF_FORM] = 1'b1;
            end
            if (|s.opcode_accumulator[31:16]) begin
               r.error_flags[EF_LARGE] = 1'b1;
            end
            r.phase = PH_PRE_PAY;
            r.token_length = 2'd0;
         end
         PH_PAY: begin
            r.phase = PH_REST;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

endpackage

@@ rtl/hex_capture_line_parser.sv @@
// Throughput: one input word per cycle while rsp_tready is high; a result held by a low
// rsp_tready stalls the input once the input register is also full.
// Each word passes an input register, then parsing logic; results land in the result register.
// Reset is synchronous and active high; it clears the line state and both valid flags.
`include "hex_capture_line_parser_defines.svh"

module hex_capture_line_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] ch
   input  logic                                req_tlast,  // line_end
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] data_byte, [10:8] status, [11] dir_is_server, [27:12] opcode_value,
   // [43:28] byte_count, [47:44] zero
   output logic [hclp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                                rsp_tuser   // kind
);
   import hclp_pkg::*;

   logic                       in_valid_ff;
   logic [7:0]                 ch_ff;
   logic                       last_ff;
   state_type                  state_ff;
   state_type                  state_in;
   logic                       out_free;
   logic                       advance;

   logic                       emit_in;
   logic                       kind_in;
   logic [7:0]                 byte_in;
   status_type                 status_in;
   logic                       server_in;
   logic [15:0]                opcode_in;
   logic [OUT_COUNT_WIDTH-1:0] count_in;
   logic [4:0]                 digit;
   logic                       skip;
   logic [32:0]                count_wide;

   logic                       rsp_valid_ff;
   logic                       kind_ff;
   logic [7:0]                 byte_ff;
   status_type                 status_ff;
   logic                       server_ff;
   logic [15:0]                opcode_ff;
   logic [OUT_COUNT_WIDTH-1:0] count_ff;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign digit      = hex_digit(ch_ff);
   assign count_wide = 33'(state_ff.payload_count);

   always_comb begin
      state_in  = state_ff;
      emit_in   = 1'b0;
      kind_in   = 1'b0;
      byte_in   = 8'h00;
      status_in = ST_OK;
      server_in = 1'b0;
      opcode_in = 16'h0000;
      count_in  = '0;
      skip      = 1'b0;
      if (last_ff) begin
         emit_in = 1'b1;
         kind_in = 1'b1;
         if (state_in.phase == PH_LSTART || state_in.phase == PH_COMMENT) begin
            status_in = ST_SKIPPED;
         end else begin
            if (state_in.phase == PH_PRE_DIR || state_in.phase == PH_DIR) begin
               state_in = close_token(state_in);
            end
            if (state_in.phase == PH_PRE_OP || state_in.phase == PH_OP) begin
               state_in = close_token(state_in);
            end
            if (state_in.error_flags[EF_DIR]) begin
               status_in = ST_BAD_DIR;
            end else if (state_in.error_flags[EF_FORM]) begin
               status_in = ST_BAD_FORM;
            end else if (state_in.error_flags[EF_OPHEX]) begin
               status_in = ST_OP_NONHEX;
            end else if (state_in.error_flags[EF_LARGE]) begin
               status_in = ST_OP_LARGE;
            end else if (state_in.nibble_half) begin
               status_in = ST_ODD_PAYLOAD;
            end else if (state_in.error_flags[EF_PAYHEX]) begin
               status_in = ST_PAY_NONHEX;
            end
            if (!state_in.error_flags[EF_DIR] && state_in.dir_char == CHAR_S) begin
               server_in = 1'b1;
            end
            if (status_in == ST_OK) begin
               opcode_in = state_in.opcode_accumulator[15:0];
            end
         end
         count_in = (|count_wide[32:OUT_COUNT_WIDTH]) ? '1 : count_wide[OUT_COUNT_WIDTH-1:0];
         state_in = STATE_RESET;
      end else begin
         if (state_in.phase == PH_LSTART) begin
            if (ch_ff == CHAR_SPACE || ch_ff == CHAR_TAB || ch_ff == CHAR_CR ||
                ch_ff == CHAR_LF) begin
               skip = 1'b1;
            end else if (ch_ff == CHAR_HASH) begin
               state_in.phase = PH_COMMENT;
               skip = 1'b1;
            end else begin
               state_in.phase = PH_PRE_DIR;
            end
         end
         if (skip || state_in.phase == PH_COMMENT || state_in.phase == PH_REST) begin
         end else if (is_ws(ch_ff)) begin
            if (state_in.phase == PH_DIR || state_in.phase == PH_OP ||
                state_in.phase == PH_PAY) begin
               state_in = close_token(state_in);
            end
         end else begin
            if (state_in.phase == PH_PRE_DIR) begin
               state_in.phase = PH_DIR;
            end else if (state_in.phase == PH_PRE_OP) begin
               state_in.phase = PH_OP;
            end else if (state_in.phase == PH_PRE_PAY) begin
               state_in.phase = PH_PAY;
            end
            if (state_in.phase == PH_DIR) begin
               if (state_in.token_length == 2'd0) begin
                  state_in.dir_char = ch_ff;
               end
               if (state_in.token_length != 2'd3) begin
                  state_in.token_length = state_in.token_length + 2'd1;
               end
            end else if (state_in.phase == PH_OP) begin
               if (state_in.token_length == 2'd0) begin
                  if (ch_ff != CHAR_ZERO) begin
                     state_in.error_flags[EF_FORM] = 1'b1;
                  end
               end else if (state_in.token_length == 2'd1) begin
                  if (ch_ff != CHAR_X_LOW && ch_ff != CHAR_X_UP) begin
                     state_in.error_flags[EF_FORM] = 1'b1;
                  end
               end else if (!digit[4]) begin
                  state_in.error_flags[EF_OPHEX] = 1'b1;
               end else begin
                  state_in.opcode_accumulator = {state_in.opcode_accumulator[27:0], digit[3:0]};
               end
               if (state_in.token_length != 2'd3) begin
                  state_in.token_length = state_in.token_length + 2'd1;
               end
            end else begin
               if (!digit[4]) begin
                  state_in.error_flags[EF_PAYHEX] = 1'b1;
               end
               if (!state_in.nibble_half) begin
                  state_in.high_nibble = digit[4] ? digit[3:0] : 4'h0;
                  state_in.nibble_half = 1'b1;
               end else begin
                  state_in.nibble_half = 1'b0;
                  if (state_in.error_flags == 5'h00) begin
                     if (state_in.payload_count != '1) begin
                        state_in.payload_count = state_in.payload_count + COUNT_WIDTH'(1);
                     end
                     emit_in = 1'b1;
                     byte_in = {state_in.high_nibble, digit[3:0]};
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         ch_ff   <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit_in) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit_in) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         status_ff <= status_in;
         server_ff <= server_in;
         opcode_ff <= opcode_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {4'h0, count_ff, opcode_ff, server_ff, status_ff, byte_ff};

   `HCLP_ASSERT_IMP(a_byte_fields_zero, clock, reset, rsp_tvalid && !rsp_tuser,
                    rsp_tdata[47:8] == 40'h0)
   `HCLP_ASSERT_IMP(a_opcode_only_ok, clock, reset,
                    rsp_tvalid && rsp_tuser && rsp_tdata[10:8] != ST_OK,
                    rsp_tdata[27:12] == 16'h0000)
   `HCLP_ASSERT_NXT(a_line_end_clears, clock, reset, advance && last_ff,
                    state_ff.phase == PH_LSTART && state_ff.payload_count == '0)
   `HCLP_ASSERT_IMP(a_line_start_clean, clock, reset, state_ff.phase == PH_LSTART,
                    !state_ff.nibble_half && state_ff.error_flags == 5'h00)

endmodule
